@@ hw/rtl/lmsl_pkg.sv @@
// Shared types and constants for the longest monotone subsequence length block.
// No dependencies; every file of the block but lmsl_ram imports this package.
package lmsl_pkg;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned LEN_W       = 11;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LEN_W-1:0]       len_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAST,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  // Result of the shared comparator: entry equals value, or the search
  // moves past the entry (also the "extend" test against the last tail).
  typedef struct packed {
    logic eq;
    logic right;
  } cmp_res_t;

  // Tails memory access from the sequencer.
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    idx_t   raddr;
  } ram_req_t;

endpackage

@@ hw/rtl/lmsl_if.sv @@
// Valid/ready channel interfaces for input items, results and the mode register.
// Depends on lmsl_pkg.
interface lmsl_in_if;
  import lmsl_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  logic   start_req;
  modport source (output valid, output value, output start_req, input ready);
  modport sink (input valid, input value, input start_req, output ready);
endinterface

interface lmsl_out_if;
  import lmsl_pkg::*;
  logic valid;
  logic ready;
  len_t length;
  logic overflow;
  modport source (output valid, output length, output overflow, input ready);
  modport sink (input valid, input length, input overflow, output ready);
endinterface

interface lmsl_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, output mode, input ready);
  modport sink (input valid, input mode, output ready);
endinterface

@@ hw/rtl/longest_monotone_subsequence_length.sv @@
// Top level: longest strictly monotone subsequence length over a value stream.
// Depends on lmsl_pkg, lmsl_if, lmsl_ram, lmsl_cmp, lmsl_ctrl.
//
//   channel  dir  payload             transaction
//   in_i     in   value, start_req    valid && ready
//   out_o    out  length, overflow    valid && ready
//   cfg_i    in   mode                valid && ready (ready tied high)
//
// Per item: a start or a skipped zero goes straight to the result; any other
// item tests the last tail, then an append or dropped append reports, else a
// search reads <= ceil(log2(top_index+2)) tails, one per cycle, compared next.
// The result register frees the memory path; a stalled result only holds the
// sequencer when the following item is ready to report. Reset clears the
// control state; the tails memory is not cleared and needs no sweep.
module longest_monotone_subsequence_length (
  input logic        clk_i,
  input logic        rst_ni,
  lmsl_in_if.sink    in_i,
  lmsl_out_if.source out_o,
  lmsl_cfg_if.sink   cfg_i
);
  import lmsl_pkg::*;

  ram_req_t ram_req;
  value_t   rd_data;
  value_t   cur_value;
  logic     incr;
  cmp_res_t cmp_res;

  lmsl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .cfg_i   (cfg_i),
    .cmp_i   (cmp_res),
    .value_o (cur_value),
    .incr_o  (incr),
    .ram_o   (ram_req)
  );

  lmsl_ram #(
    .Depth (DEPTH),
    .Width (VALUE_WIDTH)
  ) u_tails (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (rd_data)
  );

  lmsl_cmp u_cmp (
    .entry_i (rd_data),
    .value_i (cur_value),
    .incr_i  (incr),
    .res_o   (cmp_res)
  );

endmodule

@@ hw/rtl/lmsl_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module lmsl_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/lmsl_cmp.sv @@
// Shared comparator used for the last-tail test and every search probe.
// Depends on lmsl_pkg.
module lmsl_cmp (
  input  lmsl_pkg::value_t   entry_i,
  input  lmsl_pkg::value_t   value_i,
  input  logic               incr_i,
  output lmsl_pkg::cmp_res_t res_o
);
  import lmsl_pkg::*;

  assign res_o.eq    = (entry_i == value_i);
  // increasing: move past tails below the value; decreasing: past tails above
  assign res_o.right = incr_i ? (entry_i < value_i) : (entry_i > value_i);

endmodule

@@ hw/rtl/lmsl_ctrl.sv @@
// Sequencer: accepts items, drives the tails memory, runs the halving search
// and holds the result register and the mode register. Depends on lmsl_pkg, lmsl_if.
module lmsl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  lmsl_in_if.sink            in_i,
  lmsl_out_if.source         out_o,
  lmsl_cfg_if.sink           cfg_i,
  input  lmsl_pkg::cmp_res_t cmp_i,
  output lmsl_pkg::value_t   value_o,
  output logic               incr_o,
  output lmsl_pkg::ram_req_t ram_o
);
  import lmsl_pkg::*;

  state_e   state_q, state_d;
  logic     mode_q;
  idx_t     top_q, top_d;
  logic     ovf_q, ovf_d;
  value_t   val_q, val_d;
  cnt_t     lo_q, lo_d;   // search lower bound plus one
  cnt_t     hi_q, hi_d;
  idx_t     mid_q, mid_d;
  logic     out_valid_q, out_valid_d;
  len_t     len_q, len_d;
  logic     ovf_out_q, ovf_out_d;

  cnt_t          lo_n, hi_n;
  logic [CNT_W:0] mid_sum;
  idx_t          mid_n;
  logic          more;
  logic          accept;
  logic          skip;
  logic          out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign skip     = in_i.start_req || (!mode_q && (in_i.value == '0));
  assign out_free = !out_valid_q || out_o.ready;

  // next search bounds after the probe whose data is back this cycle
  always_comb begin
    lo_n    = cmp_i.right ? ({1'b0, mid_q} + cnt_t'(1)) : lo_q;
    hi_n    = cmp_i.right ? hi_q : {1'b0, mid_q};
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n} - (CNT_W+1)'(1);
    mid_n   = mid_sum[IDX_W:1];
    more    = (hi_n > lo_n);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = skip ? ST_RESULT : ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = cmp_i.right ? ST_RESULT : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cmp_i.eq || !more) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    top_d       = top_q;
    ovf_d       = ovf_q;
    val_d       = val_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    len_d       = len_q;
    ovf_out_d   = ovf_out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ram_o.we    = 1'b0;
    ram_o.waddr = top_q;
    ram_o.wdata = val_q;
    ram_o.raddr = top_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d = in_i.value;
          if (in_i.start_req) begin
            // new sequence: tail 0 takes the value, the rest is a no-op
            ram_o.we    = 1'b1;
            ram_o.waddr = '0;
            ram_o.wdata = in_i.value;
            top_d       = '0;
            ovf_d       = 1'b0;
          end
        end
      end
      ST_LAST: begin
        if (cmp_i.right) begin
          if (top_q != idx_t'(DEPTH - 1)) begin
            top_d       = top_q + idx_t'(1);
            ram_o.we    = 1'b1;
            ram_o.waddr = top_q + idx_t'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          lo_d        = '0;
          hi_d        = {1'b0, top_q} + cnt_t'(1);
          mid_d       = top_q >> 1;
          ram_o.raddr = top_q >> 1;
        end
      end
      ST_SEARCH: begin
        if (cmp_i.eq) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = mid_q;
        end else begin
          lo_d = lo_n;
          hi_d = hi_n;
          if (more) begin
            mid_d       = mid_n;
            ram_o.raddr = mid_n;
          end else begin
            ram_o.we    = 1'b1;
            ram_o.waddr = hi_n[IDX_W-1:0];
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          len_d       = LEN_W'({1'b0, top_q} + cnt_t'(1));
          ovf_out_d   = ovf_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      top_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        mode_q <= cfg_i.mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    len_q     <= len_d;
    ovf_out_q <= ovf_out_d;
  end

  assign in_i.ready     = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.length   = len_q;
  assign out_o.overflow = ovf_out_q;
  assign value_o        = val_q;
  assign incr_o         = mode_q;

endmodule

@@ verif/lmsl_length_checker.sv @@
// Scoreboard for the longest monotone subsequence length block: watches the
// input, result and mode channels, predicts each result and compares it.
// Depends on lmsl_pkg and the channel interfaces in lmsl_if.
module lmsl_length_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lmsl_in_if   in_mon,
  lmsl_out_if  out_mon,
  lmsl_cfg_if  cfg_mon,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lmsl_pkg::*;

  typedef struct packed {
    len_t length;
    logic overflow;
  } seq_result_t;

  value_t      tail_ends [DEPTH];
  int unsigned longest_idx    = 0;
  logic        append_dropped = 1'b0;
  logic        increasing     = 1'b0;
  seq_result_t expected_lengths [$];

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Halving search over 0..longest_idx; stops on an equal entry.
  function automatic int unsigned find_slot(value_t v);
    int     lo;
    int     hi;
    int     mid;
    value_t t;
    lo = -1;
    hi = int'(longest_idx) + 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      t = tail_ends[mid];
      if (t == v) return mid;
      if (increasing ? (t < v) : (t > v)) lo = mid;
      else hi = mid;
    end
    return hi;
  endfunction

  function automatic seq_result_t advance_tails(value_t v, logic first);
    int unsigned slot;
    logic        grow;
    if (first) begin
      tail_ends[0]   = v;
      longest_idx    = 0;
      append_dropped = 1'b0;
    end
    // zeros are skipped only when looking for a decreasing run
    if (increasing || v != '0) begin
      grow = increasing ? (v > tail_ends[longest_idx]) : (v < tail_ends[longest_idx]);
      if (grow) begin
        if (longest_idx + 1 < DEPTH) begin
          longest_idx++;
          tail_ends[longest_idx] = v;
        end else begin
          append_dropped = 1'b1;
        end
      end else begin
        slot = find_slot(v);
        if (slot <= longest_idx) tail_ends[slot] = v;
      end
    end
    return '{length: len_t'(longest_idx + 1), overflow: append_dropped};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    seq_result_t got;
    seq_result_t want;
    if (!rst_ni) begin
      increasing     = 1'b0;
      longest_idx    = 0;
      append_dropped = 1'b0;
      expected_lengths.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = '{length: out_mon.length, overflow: out_mon.overflow};
        if (expected_lengths.size() == 0) begin
          report_mismatch($sformatf("result (length %0d overflow %0b) with none expected",
                                    got.length, got.overflow));
        end else begin
          want = expected_lengths.pop_front();
          if (got.length !== want.length) begin
            report_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
          end
          if (got.overflow !== want.overflow) begin
            report_mismatch($sformatf("overflow %0b, expected %0b",
                                      got.overflow, want.overflow));
          end
        end
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        increasing = cfg_mon.mode;
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        expected_lengths.push_back(advance_tails(in_mon.value, in_mon.start_req));
      end
    end
    pending = expected_lengths.size();
  end

endmodule

@@ verif/longest_monotone_subsequence_length_test.sv @@
// Testbench top for longest_monotone_subsequence_length: clock, reset, stimulus
// and verdict. Depends on lmsl_pkg, lmsl_if, the block and lmsl_length_checker.
module longest_monotone_subsequence_length_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lmsl_pkg::*;

  localparam logic MODE_DECREASING = 1'b0;
  localparam logic MODE_INCREASING = 1'b1;
  localparam int   RANDOM_ITEMS    = 528;

  typedef enum int {VS_WIDE, VS_NARROW, VS_RISING, VS_FALLING} value_style_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   mismatches;
  int   pending;

  lmsl_in_if  in_ch ();
  lmsl_out_if out_ch ();
  lmsl_cfg_if cfg_ch ();

  always #10 clk_i = ~clk_i;

  longest_monotone_subsequence_length uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  lmsl_length_checker scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Called on a rising edge; returns on the edge where the transaction happens.
  task automatic send_item(value_t v, logic first);
    if (int'($urandom_range(99)) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while (int'($urandom_range(99)) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.start_req <= first;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.mode  <= m;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    int           sent;
    int           run_len;
    logic         fresh;
    value_style_e style;
    value_t       cur;
    value_t       v;
    sent = 0;
    while (sent < count) begin
      // mostly new sequences; a few runs keep extending the current table
      fresh   = ($urandom_range(9) != 0);
      run_len = ($urandom_range(4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      style   = value_style_e'($urandom_range(3));
      cur     = $urandom;
      for (int i = 0; i < run_len && sent < count; i++) begin
        case (style)
          VS_WIDE: begin
            v = $urandom;
          end
          VS_NARROW: begin
            v = $urandom_range(7);
            if ($urandom_range(1) == 0) v = ~v;
          end
          VS_RISING: begin
            cur = cur + $urandom_range(0, 8);
            v = ($urandom_range(7) == 0) ? cur - $urandom_range(0, 40) : cur;
          end
          default: begin
            cur = cur - $urandom_range(0, 8);
            v = ($urandom_range(7) == 0) ? cur + $urandom_range(0, 40) : cur;
          end
        endcase
        send_item(v, (i == 0 && fresh) || $urandom_range(49) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.start_req <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.mode     <= MODE_DECREASING;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, equal values, skipped zeros, restarts, mode flips mid-sequence
    write_mode(MODE_DECREASING);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0);
    write_mode(MODE_INCREASING);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b0);
    write_mode(MODE_DECREASING);
    send_item(32'h6000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h6000_0000, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      write_mode((ph % 2 == 0) ? MODE_DECREASING : MODE_INCREASING);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      run_random(RANDOM_ITEMS / 8);
      // full drain, then the other direction applied to whatever table is live
      write_mode((ph % 2 == 0) ? MODE_INCREASING : MODE_DECREASING);
      run_random(RANDOM_ITEMS / 8);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
